@@ rtl/alf_pkg.sv @@
package alf_pkg;

  // request codes
  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_PARTICLE = 2'd1;
  localparam logic [1:0] REQ_QUERY    = 2'd2;

  // adaptation actions
  localparam logic [1:0] ACT_IDLE     = 2'd0;
  localparam logic [1:0] ACT_REFINE   = 2'd1;
  localparam logic [1:0] ACT_COMPRESS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PEAK          = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE     = 2'd1;
  localparam logic [1:0] CFG_LEVEL_COUNT   = 2'd2;
  localparam logic [1:0] CFG_SURFACE_LEVEL = 2'd3;

  // configuration reset values
  localparam logic [31:0] PEAK_RESET          = 32'd327680;
  localparam logic [15:0] TOLERANCE_RESET     = 16'd6554;
  localparam logic [3:0]  LEVEL_COUNT_RESET   = 4'd3;
  localparam logic [3:0]  SURFACE_LEVEL_RESET = 4'd3;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int IDX_EXT_BITS   = 17;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] prop_value;
    logic [9:0]  node_index;
    logic        near_surface;
    logic        particle_active;
    logic [3:0]  node_level;
  } in_item_t;

  typedef struct packed {
    logic [3:0] particle_level;
    logic [3:0] target_level;
    logic       node_active;
    logic [1:0] adapt_action;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lvl_step;
    logic clr_wr;
    logic finish;
  } alf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lvl_done;
    logic clr_last;
  } alf_status_t;

endpackage

@@ rtl/adaptive_level_flagger_core.sv @@
// per item: a query or unused code goes straight to the result, a particle
// request runs one threshold multiply per level, and a clear writes one table
// entry per cycle; one item at a time, so no new item is taken until the result
// of the last one is handed to the output, which waits while out_stall holds it;
// reset (rst, synchronous, active high) loads the register defaults and then
// sweeps the node table with stall high
module adaptive_level_flagger_core #(
  parameter int NODE_COUNT = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  alf_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output alf_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [alf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [alf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import alf_pkg::*;

  alf_cmd_t    cmd;
  alf_status_t status;

  // sequencer: sweep, threshold loop, table update and result handoff
  alf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_req    (in_item.req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // config registers, threshold multiplier, node table and result register
  alf_dpath #(
    .NODE_COUNT (NODE_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

@@ rtl/alf_ram.sv @@
module alf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/alf_ctrl.sv @@
module alf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_req,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  alf_pkg::alf_status_t status,
  output alf_pkg::alf_cmd_t    cmd
);
  import alf_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_LEVEL  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_req == REQ_CLEAR) begin
            state_next = S_CLEAR;
          end else if (in_req == REQ_PARTICLE) begin
            state_next = S_LEVEL;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_FINISH;
        end
      end
      S_LEVEL: begin
        if (status.lvl_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.lvl_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/alf_dpath.sv @@
module alf_dpath #(
  parameter int NODE_COUNT = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  alf_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [alf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [alf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  alf_pkg::alf_cmd_t                   cmd,
  output alf_pkg::alf_status_t                status,
  output alf_pkg::out_item_t                  out_item
);
  import alf_pkg::*;

  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int AW = $clog2(NODE_COUNT);
  localparam int PW = VW + 16;

  // configuration registers
  logic [31:0] peak;
  logic [15:0] tolerance;
  logic [3:0]  level_count;
  logic [3:0]  surface_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak          <= PEAK_RESET;
      tolerance     <= TOLERANCE_RESET;
      level_count   <= LEVEL_COUNT_RESET;
      surface_level <= SURFACE_LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PEAK:          peak          <= cfg_data;
        CFG_TOLERANCE:     tolerance     <= cfg_data[15:0];
        CFG_LEVEL_COUNT:   level_count   <= cfg_data[3:0];
        CFG_SURFACE_LEVEL: surface_level <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]    req;
  logic [VW-1:0] value;
  logic [9:0]    idx;
  logic          near;
  logic          act;
  logic [3:0]    cur_level;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req       <= in_item.req_type;
      value     <= in_item.prop_value[VW-1:0];
      idx       <= in_item.node_index;
      near      <= in_item.near_surface;
      act       <= in_item.particle_active;
      cur_level <= in_item.node_level;
    end
  end

  // threshold chain, one multiply per step
  logic [VW-1:0] thr;
  logic [3:0]    lv;
  logic [VW-1:0] mul_a;
  logic [PW-1:0] prod;

  assign mul_a = cmd.capture ? peak[VW-1:0] : thr;
  assign prod  = PW'(mul_a) * PW'(tolerance);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      thr <= prod[PW-1:16];
      lv  <= level_count;
    end else if (cmd.lvl_step) begin
      thr <= prod[PW-1:16];
      lv  <= lv - 4'd1;
    end
  end

  assign status.lvl_done = (lv == 4'd0) || (value >= thr);

  // clear sweep pointer
  logic [AW-1:0] clr_ptr;
  logic          clr_last;

  assign clr_last        = (clr_ptr == AW'(NODE_COUNT - 1));
  assign status.clr_last = clr_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_wr) begin
      clr_ptr <= clr_last ? '0 : clr_ptr + AW'(1);
    end
  end

  // node table: {level, active}
  logic [IDX_EXT_BITS-1:0] in_idx_ext;
  logic [IDX_EXT_BITS-1:0] idx_ext;
  logic                    idx_ok;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [4:0]              ram_wdata;
  logic [4:0]              ram_rdata;
  logic [3:0]              old_level;
  logic                    old_active;
  logic [3:0]              new_level;
  logic                    new_active;

  assign in_idx_ext = IDX_EXT_BITS'(in_item.node_index);
  assign idx_ext    = IDX_EXT_BITS'(idx);
  assign idx_ok     = (idx_ext < IDX_EXT_BITS'(NODE_COUNT));
  assign old_level  = ram_rdata[4:1];
  assign old_active = ram_rdata[0];

  always_comb begin
    if (near) begin
      new_level = surface_level;
    end else if (lv > old_level) begin
      new_level = lv;
    end else begin
      new_level = old_level;
    end
    new_active = old_active | act;
  end

  assign ram_we    = cmd.clr_wr || (cmd.finish && (req == REQ_PARTICLE) && idx_ok);
  assign ram_waddr = cmd.clr_wr ? clr_ptr : idx_ext[AW-1:0];
  assign ram_wdata = cmd.clr_wr ? 5'd0 : {new_level, new_active};

  alf_ram #(
    .WIDTH (5),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // result
  out_item_t res;

  always_comb begin
    res = '0;
    case (req)
      REQ_PARTICLE: begin
        res.particle_level = lv;
        if (idx_ok) begin
          res.target_level = new_level;
          res.node_active  = new_active;
        end
      end
      REQ_QUERY: begin
        if (idx_ok) begin
          res.target_level = old_level;
          res.node_active  = old_active;
          if (old_level > cur_level) begin
            res.adapt_action = ACT_REFINE;
          end else if (old_level < cur_level) begin
            res.adapt_action = ACT_COMPRESS;
          end else begin
            res.adapt_action = ACT_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item <= res;
    end
  end

endmodule
